// File: rtl/core/bu_pkg.sv
// Shared types and constants of the bilinear upscaler.
// No dependencies; the other files of the block, bar bu_ram, refer to this package by scoped names.
package bu_pkg;

  // Store and field geometry
  localparam int SRC_MAX_W   = 64;
  localparam int SRC_MAX_H   = 64;
  localparam int DST_MAX     = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int IDX_BITS    = 6;    // source column or row index
  localparam int COORD_BITS  = 12;   // output coordinate
  localparam int SIZE_BITS   = 7;    // source size register
  localparam int DST_BITS    = 13;   // destination size register
  localparam int FRAC_BITS   = 16;   // Q0.16 blend weight

  // Axis mapping: (x*s) << FRAC_BITS divided by d gives index and fraction in one quotient
  localparam int NUM_BITS    = COORD_BITS + IDX_BITS;
  localparam int QUO_BITS    = IDX_BITS + FRAC_BITS;
  localparam int REM_BITS    = COORD_BITS;
  localparam int DIV_STAGES  = QUO_BITS / 2;  // two quotient bits per stage

  localparam int ADDR_BITS   = 2 * IDX_BITS;
  localparam int STORE_DEPTH = SRC_MAX_W * SRC_MAX_H;

  localparam int QUEUE_DEPTH   = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = DST_BITS;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    cmd_e                          cmd;
    logic [IDX_BITS-1:0]           src_col;
    logic [IDX_BITS-1:0]           src_row;
    logic signed [SAMPLE_BITS-1:0] src_value;
    logic [COORD_BITS-1:0]         out_col;
    logic [COORD_BITS-1:0]         out_row;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_value;
    logic [COORD_BITS-1:0]         res_col;
    logic [COORD_BITS-1:0]         res_row;
    logic                          coord_error;
  } out_item_t;

  // Effective image sizes after clamping
  typedef struct packed {
    logic [SIZE_BITS-1:0] sw;
    logic [SIZE_BITS-1:0] sh;
    logic [DST_BITS-1:0]  dw;
    logic [DST_BITS-1:0]  dh;
  } sizes_t;

  // Classified item passed from front to back
  typedef struct packed {
    cmd_e                   cmd;
    logic [IDX_BITS-1:0]    wcol;
    logic [IDX_BITS-1:0]    wrow;
    logic [SAMPLE_BITS-1:0] wval;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic                   err;
    logic [NUM_BITS-1:0]    num_x;
    logic [NUM_BITS-1:0]    num_y;
  } op_t;

endpackage

// File: rtl/core/bilinear_upscaler.sv
// Top level of the bilinear upscaler: front, queue and back wired together.
// Depends on bu_pkg, bu_front, bu_fifo and bu_back.
//
// Usage:
//   The input channel (in_valid_i/in_ready_o/in_data_i) takes one beat per item.
//   A write beat (cmd = write) stores src_value at (src_col, src_row) and yields no
//   result. A query beat names (out_col, out_row) and yields exactly one result beat
//   on out_valid_o/out_ready_i/out_data_o, in item order.
//   Size registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write
//   them only while idle, as the block does not enforce it; all four reset to 64.
// Timing:
//   One item per cycle sustained while out_ready_i stays high. A query result reaches
//   out_valid_o through one front register, one queue slot, eleven division stages of
//   two quotient bits each, the store read and three blend/round registers. The store
//   is held in four copies so the four neighbors are read in the same cycle.
// Reset and stall:
//   Reset empties the queue and pipeline; the store contents stay undefined until
//   written. When the receiver holds out_ready_i low, the result is held, the back stops,
//   the queue takes QUEUE_DEPTH items, the front register one more, then in_ready_o drops.
module bilinear_upscaler #(
  parameter int QUEUE_DEPTH = bu_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  bu_pkg::in_item_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output bu_pkg::out_item_t                out_data_o,
  input  logic                             cfg_we_i,
  input  logic [bu_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [bu_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  bu_pkg::sizes_t sizes;
  bu_pkg::op_t    push_op, head_op;
  logic           push, full, pop, empty;

  // Accept, classify and multiply
  bu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sizes_o    (sizes),
    .push_o     (push),
    .op_o       (push_op),
    .full_i     (full)
  );

  // Decouple the two halves
  bu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_op),
    .empty_o (empty)
  );

  // Divide, read neighbors, blend
  bu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sizes_i     (sizes),
    .op_valid_i  (!empty),
    .op_i        (head_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/core/bu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; hold the data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bu_fifo.sv
// Short queue of classified items between the front and the back of the upscaler.
// Depends on bu_pkg for the item type.
module bu_fifo #(
  parameter int DEPTH = bu_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  bu_pkg::op_t data_i,
  output logic        full_o,
  input  logic        pop_i,
  output bu_pkg::op_t data_o,
  output logic        empty_o
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  bu_pkg::op_t         mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CNT_BITS'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed beats
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/bu_front.sv
// Front of the upscaler: size registers, input handshake, classification and axis products.
// Depends on bu_pkg; feeds bu_fifo.
module bu_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  bu_pkg::in_item_t                   in_data_i,
  input  logic                               cfg_we_i,
  input  logic [bu_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [bu_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output bu_pkg::sizes_t                     sizes_o,
  output logic                               push_o,
  output bu_pkg::op_t                        op_o,
  input  logic                               full_i
);

  localparam int SB = bu_pkg::SIZE_BITS;
  localparam int DB = bu_pkg::DST_BITS;
  localparam int PB = bu_pkg::COORD_BITS + bu_pkg::SIZE_BITS;

  logic [SB-1:0] src_w_q, src_w_d, src_h_q, src_h_d;
  logic [DB-1:0] dst_w_q, dst_w_d, dst_h_q, dst_h_d;
  logic          f_vld_q, f_vld_d;
  bu_pkg::op_t   op_q, op_d;
  logic          accept;
  logic [PB-1:0] px, py;

  // Zero acts as one, anything above the limit acts as the limit
  function automatic logic [DB-1:0] clamp_size(input logic [DB-1:0] v, input logic [DB-1:0] hi);
    logic [DB-1:0] r;
    if (v == '0) begin
      r = DB'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Decode configuration writes
  always_comb begin
    src_w_d = src_w_q;
    src_h_d = src_h_q;
    dst_w_d = dst_w_q;
    dst_h_d = dst_h_q;
    if (cfg_we_i) begin
      case (bu_pkg::cfg_idx_e'(cfg_idx_i))
        bu_pkg::CFG_SRC_WIDTH:  src_w_d = cfg_data_i[SB-1:0];
        bu_pkg::CFG_SRC_HEIGHT: src_h_d = cfg_data_i[SB-1:0];
        bu_pkg::CFG_DST_WIDTH:  dst_w_d = cfg_data_i;
        bu_pkg::CFG_DST_HEIGHT: dst_h_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SB'(64);
      src_h_q <= SB'(64);
      dst_w_q <= DB'(64);
      dst_h_q <= DB'(64);
    end else begin
      src_w_q <= src_w_d;
      src_h_q <= src_h_d;
      dst_w_q <= dst_w_d;
      dst_h_q <= dst_h_d;
    end
  end

  // Effective sizes
  always_comb begin
    sizes_o.sw = SB'(clamp_size(DB'(src_w_q), DB'(bu_pkg::SRC_MAX_W)));
    sizes_o.sh = SB'(clamp_size(DB'(src_h_q), DB'(bu_pkg::SRC_MAX_H)));
    sizes_o.dw = clamp_size(dst_w_q, DB'(bu_pkg::DST_MAX));
    sizes_o.dh = clamp_size(dst_h_q, DB'(bu_pkg::DST_MAX));
  end

  // Take a beat whenever the holding register is free or drains this cycle
  assign in_ready_o = !f_vld_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = f_vld_q && !full_i;
  assign op_o       = op_q;

  // Classify the beat and form the axis products
  always_comb begin
    px         = in_data_i.out_col * sizes_o.sw;
    py         = in_data_i.out_row * sizes_o.sh;
    op_d.cmd   = in_data_i.cmd;
    op_d.wcol  = in_data_i.src_col;
    op_d.wrow  = in_data_i.src_row;
    op_d.wval  = in_data_i.src_value;
    op_d.x     = in_data_i.out_col;
    op_d.y     = in_data_i.out_row;
    op_d.err   = ({1'b0, in_data_i.out_col} >= sizes_o.dw) ||
                 ({1'b0, in_data_i.out_row} >= sizes_o.dh);
    op_d.num_x = px[bu_pkg::NUM_BITS-1:0];
    op_d.num_y = py[bu_pkg::NUM_BITS-1:0];
  end

  always_comb begin
    f_vld_d = f_vld_q;
    if (accept) begin
      f_vld_d = 1'b1;
    end else if (push_o) begin
      f_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= f_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_d;
    end
  end

endmodule

// File: rtl/core/bu_back.sv
// Back of the upscaler: pipelined axis division, replicated source store, blend and output.
// Depends on bu_pkg and bu_ram; pops items from bu_fifo.
module bu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bu_pkg::sizes_t    sizes_i,
  input  logic              op_valid_i,
  input  bu_pkg::op_t       op_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bu_pkg::out_item_t out_data_o
);

  localparam int NS   = bu_pkg::DIV_STAGES;
  localparam int QB   = bu_pkg::QUO_BITS;
  localparam int RB   = bu_pkg::REM_BITS;
  localparam int FB   = bu_pkg::FRAC_BITS;
  localparam int IB   = bu_pkg::IDX_BITS;
  localparam int CB   = bu_pkg::COORD_BITS;
  localparam int SB   = bu_pkg::SIZE_BITS;
  localparam int DB   = bu_pkg::DST_BITS;
  localparam int WB   = bu_pkg::SAMPLE_BITS;
  localparam int AB   = bu_pkg::ADDR_BITS;
  localparam int TOPB = WB + FB;
  localparam int ACCB = TOPB + FB;
  localparam int P1B  = WB + FB + 2;
  localparam int P2B  = TOPB + FB + 2;
  localparam logic [WB-1:0]   BIAS     = WB'(1) << (WB - 1);
  localparam logic [ACCB-1:0] RND_HALF = ACCB'(1) << (TOPB - 1);

  typedef struct packed {
    bu_pkg::cmd_e   cmd;
    logic [IB-1:0]  wcol;
    logic [IB-1:0]  wrow;
    logic [WB-1:0]  wval;
    logic [CB-1:0]  x;
    logic [CB-1:0]  y;
    logic           err;
    logic [RB-1:0]  rx;
    logic [RB-1:0]  ry;
    logic [QB-1:0]  qx;
    logic [QB-1:0]  qy;
    logic [IB-1:0]  lx;
    logic [IB-1:0]  ly;
  } div_t;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          err;
    logic [FB-1:0] fx;
    logic [FB-1:0] fy;
  } mid_t;

  typedef struct packed {
    logic [CB-1:0]   x;
    logic [CB-1:0]   y;
    logic            err;
    logic [FB-1:0]   fy;
    logic [TOPB-1:0] top;
    logic [TOPB-1:0] bot;
  } p1_t;

  typedef struct packed {
    logic [CB-1:0]   x;
    logic [CB-1:0]   y;
    logic            err;
    logic [ACCB-1:0] acc;
  } p2_t;

  // One restoring division step: returns {quotient bit, new remainder}
  function automatic logic [RB:0] div_step(input logic [RB-1:0] rem, input logic bit_in,
                                           input logic [DB-1:0] d);
    logic [RB:0] trial;
    logic [RB:0] diff;
    logic [RB:0] r;
    trial = {rem, bit_in};
    diff  = trial - (RB + 1)'(d);
    if (trial >= (RB + 1)'(d)) begin
      r = {1'b1, diff[RB-1:0]};
    end else begin
      r = {1'b0, trial[RB-1:0]};
    end
    return r;
  endfunction

  logic              adv;
  logic [NS-1:0]     st_vld_q;
  div_t              st_q [NS];
  div_t              st_d [NS];
  div_t              init_s;
  div_t              s_last;
  logic              m_vld_q, p1_vld_q, p2_vld_q, o_vld_q;
  mid_t              m_q, m_d;
  p1_t               p1_q, p1_d;
  p2_t               p2_q, p2_d;
  bu_pkg::out_item_t o_q, o_d;

  logic [IB-1:0]     qix, qiy, x0, x1, y0, y1;
  logic [SB-1:0]     lim_x, lim_y, hi_x, hi_y;
  logic              nz_x, nz_y, ram_we;
  logic [AB-1:0]     raddr [4];
  logic [WB-1:0]     rdata [4];

  // The whole back advances together unless the output register is held
  assign adv   = !o_vld_q || out_ready_i;
  assign pop_o = adv && op_valid_i;

  // Split the axis products into leading remainder and trailing dividend bits
  always_comb begin
    init_s      = '0;
    init_s.cmd  = op_i.cmd;
    init_s.wcol = op_i.wcol;
    init_s.wrow = op_i.wrow;
    init_s.wval = op_i.wval;
    init_s.x    = op_i.x;
    init_s.y    = op_i.y;
    init_s.err  = op_i.err;
    init_s.rx   = op_i.num_x[bu_pkg::NUM_BITS-1:IB];
    init_s.ry   = op_i.num_y[bu_pkg::NUM_BITS-1:IB];
    init_s.lx   = op_i.num_x[IB-1:0];
    init_s.ly   = op_i.num_y[IB-1:0];
  end

  // Division pipeline, two quotient bits per stage for each axis
  for (genvar k = 0; k < NS; k++) begin : g_div
    div_t          s_in, s_out;
    logic [QB-1:0] vx, vy;
    logic [RB:0]   a0, a1, b0, b1;

    if (k == 0) begin : g_first
      assign s_in = init_s;
    end else begin : g_next
      assign s_in = st_q[k-1];
    end

    always_comb begin
      s_out = s_in;
      vx    = {s_in.lx, {FB{1'b0}}};
      vy    = {s_in.ly, {FB{1'b0}}};
      a0    = div_step(s_in.rx, vx[QB-1-2*k], sizes_i.dw);
      a1    = div_step(a0[RB-1:0], vx[QB-2-2*k], sizes_i.dw);
      b0    = div_step(s_in.ry, vy[QB-1-2*k], sizes_i.dh);
      b1    = div_step(b0[RB-1:0], vy[QB-2-2*k], sizes_i.dh);
      s_out.rx = a1[RB-1:0];
      s_out.ry = b1[RB-1:0];
      s_out.qx = {s_in.qx[QB-3:0], a0[RB], a1[RB]};
      s_out.qy = {s_in.qy[QB-3:0], b0[RB], b1[RB]};
    end

    assign st_d[k] = s_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= '0;
    end else if (adv) begin
      st_vld_q <= {st_vld_q[NS-2:0], op_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Neighbor indices: floor index, next index when the remainder is nonzero, both clamped
  assign s_last = st_q[NS-1];

  always_comb begin
    qix   = s_last.qx[QB-1:FB];
    qiy   = s_last.qy[QB-1:FB];
    nz_x  = (s_last.qx[FB-1:0] != '0) || (s_last.rx != '0);
    nz_y  = (s_last.qy[FB-1:0] != '0) || (s_last.ry != '0);
    lim_x = sizes_i.sw - 1'b1;
    lim_y = sizes_i.sh - 1'b1;
    hi_x  = {1'b0, qix} + SB'(nz_x);
    hi_y  = {1'b0, qiy} + SB'(nz_y);
    x0    = ({1'b0, qix} > lim_x) ? lim_x[IB-1:0] : qix;
    y0    = ({1'b0, qiy} > lim_y) ? lim_y[IB-1:0] : qiy;
    x1    = (hi_x > lim_x) ? lim_x[IB-1:0] : hi_x[IB-1:0];
    y1    = (hi_y > lim_y) ? lim_y[IB-1:0] : hi_y[IB-1:0];
    raddr[0] = {y0, x0};
    raddr[1] = {y0, x1};
    raddr[2] = {y1, x0};
    raddr[3] = {y1, x1};
  end

  // Writes take effect in item order, at the same stage that queries read
  assign ram_we = adv && st_vld_q[NS-1] && (s_last.cmd == bu_pkg::CMD_WRITE);

  // Four copies of the store give four neighbor reads per cycle while the back advances
  for (genvar t = 0; t < 4; t++) begin : g_tap
    bu_ram #(
      .WIDTH (WB),
      .DEPTH (bu_pkg::STORE_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i ({s_last.wrow, s_last.wcol}),
      .wdata_i (s_last.wval),
      .re_i    (adv),
      .raddr_i (raddr[t]),
      .rdata_o (rdata[t])
    );
  end

  // Fractions travel alongside the store read
  always_comb begin
    m_d.x   = s_last.x;
    m_d.y   = s_last.y;
    m_d.err = s_last.err;
    m_d.fx  = s_last.qx[FB-1:0];
    m_d.fy  = s_last.qy[FB-1:0];
  end

  // Horizontal blend on biased samples: top = tl*2^16 + (tr - tl)*fx
  always_comb begin
    logic [WB-1:0]        tl_b, tr_b, bl_b, br_b;
    logic signed [WB:0]   dt, db;
    logic signed [FB:0]   fx_s;
    logic signed [P1B-1:0] pt, pb, st, sb;
    tl_b = rdata[0] ^ BIAS;
    tr_b = rdata[1] ^ BIAS;
    bl_b = rdata[2] ^ BIAS;
    br_b = rdata[3] ^ BIAS;
    dt   = $signed({1'b0, tr_b}) - $signed({1'b0, tl_b});
    db   = $signed({1'b0, br_b}) - $signed({1'b0, bl_b});
    fx_s = $signed({1'b0, m_q.fx});
    pt   = dt * fx_s;
    pb   = db * fx_s;
    st   = $signed({2'b00, tl_b, {FB{1'b0}}}) + pt;
    sb   = $signed({2'b00, bl_b, {FB{1'b0}}}) + pb;
    p1_d.x   = m_q.x;
    p1_d.y   = m_q.y;
    p1_d.err = m_q.err;
    p1_d.fy  = m_q.fy;
    p1_d.top = st[TOPB-1:0];
    p1_d.bot = sb[TOPB-1:0];
  end

  // Vertical blend: acc = top*2^16 + (bot - top)*fy
  always_comb begin
    logic signed [TOPB:0]  da;
    logic signed [FB:0]    fy_s;
    logic signed [P2B-1:0] pa, sa;
    da   = $signed({1'b0, p1_q.bot}) - $signed({1'b0, p1_q.top});
    fy_s = $signed({1'b0, p1_q.fy});
    pa   = da * fy_s;
    sa   = $signed({2'b00, p1_q.top, {FB{1'b0}}}) + pa;
    p2_d.x   = p1_q.x;
    p2_d.y   = p1_q.y;
    p2_d.err = p1_q.err;
    p2_d.acc = sa[ACCB-1:0];
  end

  // Round to nearest, remove the bias, force zero on a coordinate error
  always_comb begin
    logic [ACCB-1:0] rnd;
    logic [WB-1:0]   val;
    rnd = p2_q.acc + RND_HALF;
    val = rnd[ACCB-1:TOPB];
    o_d.out_value   = p2_q.err ? '0 : $signed(val ^ BIAS);
    o_d.res_col     = p2_q.x;
    o_d.res_row     = p2_q.y;
    o_d.coord_error = p2_q.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q  <= 1'b0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else if (adv) begin
      m_vld_q  <= st_vld_q[NS-1] && (s_last.cmd == bu_pkg::CMD_QUERY);
      p1_vld_q <= m_vld_q;
      p2_vld_q <= p1_vld_q;
      o_vld_q  <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q  <= m_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
      o_q  <= o_d;
    end
  end

  assign out_valid_o = o_vld_q;
  assign out_data_o  = o_q;

endmodule

// File: rtl/core/bu_checker.sv
// Port-level checks of the bilinear upscaler, attached to the top level by bind.
// Depends on bu_pkg and bilinear_upscaler.
module bu_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input bu_pkg::in_item_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input bu_pkg::out_item_t out_data_o
);

  logic [15:0] pending_q;
  logic        q_in, q_out;

  assign q_in  = in_valid_i && in_ready_o && (in_data_i.cmd == bu_pkg::CMD_QUERY);
  assign q_out = out_valid_o && out_ready_i;

  // Count queries accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      case ({q_in, q_out})
        2'b10:   pending_q <= pending_q + 1'b1;
        2'b01:   pending_q <= pending_q - 1'b1;
        default: pending_q <= pending_q;
      endcase
    end
  end

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // No result without an outstanding query
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result beat without an outstanding query");

  // A coordinate error carries a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.coord_error |-> out_data_o.out_value == '0)
    else $error("coordinate error with nonzero value");

  // Nothing shows at the output right after reset release
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat present at reset release");

endmodule

bind bilinear_upscaler bu_checker u_bu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
